@@ sv/struct_init_table_interpreter_unit_assert.svh @@
// Assertion macros used by the init-table interpreter back end.
// Expects clk and rst (synchronous, active high) in the calling scope.
`ifndef STRUCT_INIT_TABLE_INTERPRETER_UNIT_ASSERT_SVH
`define STRUCT_INIT_TABLE_INTERPRETER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SITIU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitiu assertion failed");

// Next-cycle implication.
`define SITIU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitiu assertion failed");

`endif

@@ sv/sitiu_pkg.sv @@
// Package for the init-table interpreter: command field codes, job type, helpers.
// No dependencies.
`default_nettype none

package sitiu_pkg;

  localparam int WR_OFS_W = 24;

  // Unit size codes, command bits 5..4
  localparam logic [1:0] SIZE_LONG = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  // Command type codes, command bits 7..6
  localparam logic [1:0] TYPE_COPY   = 2'd0;
  localparam logic [1:0] TYPE_REPEAT = 2'd1;
  localparam logic [1:0] TYPE_OFF8   = 2'd2;
  localparam logic [1:0] TYPE_OFF24  = 2'd3;

  typedef enum logic [0:0] {
    JOB_RUN = 1'b0,
    JOB_END = 1'b1
  } job_kind_t;

  // One queued job: a run of count units of the given size, or the end marker.
  typedef struct packed {
    job_kind_t        kind;
    logic [1:0]       size;
    logic [4:0]       count;
    logic [3:0][7:0]  data;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Index of the last byte of a unit.
  function automatic logic [1:0] last_idx(input logic [1:0] size);
    logic [1:0] r;
    case (size)
      SIZE_LONG: r = 2'd3;
      SIZE_WORD: r = 2'd1;
      default:   r = 2'd0;
    endcase
    return r;
  endfunction

  // Bytes in a run: count times unit size.
  function automatic logic [6:0] run_len(input logic [4:0] count, input logic [1:0] size);
    logic [6:0] r;
    case (size)
      SIZE_LONG: r = {count, 2'b00};
      SIZE_WORD: r = {1'b0, count, 1'b0};
      default:   r = {2'b00, count};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/sitiu_in_if.sv @@
// Table byte input channel: valid/ready handshake with one byte of payload.
// No dependencies.
`default_nettype none

interface sitiu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;

  modport source (output valid, output table_byte, input ready);
  modport sink (input valid, input table_byte, output ready);
endinterface

`default_nettype wire

@@ sv/sitiu_out_if.sv @@
// Write result channel: valid/ready handshake with offset, data and flags.
// Depends on sitiu_pkg.
`default_nettype none

interface sitiu_out_if
  import sitiu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [WR_OFS_W-1:0] write_offset;
  logic [7:0]          write_data;
  logic                write_enable;
  logic                last_of_run;
  logic                table_end;

  modport source (output valid, output write_offset, output write_data,
                  output write_enable, output last_of_run, output table_end,
                  input ready);
  modport sink (input valid, input write_offset, input write_data,
                input write_enable, input last_of_run, input table_end,
                output ready);
endinterface

`default_nettype wire

@@ sv/sitiu_front.sv @@
// Front end: parses table bytes, tracks the destination offset, emits jobs.
// Depends on sitiu_pkg and sitiu_in_if.
`default_nettype none

module sitiu_front
  import sitiu_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  sitiu_in_if.sink                    tbl,
  input  wire q_stat_t                q_stat,
  output logic                        push,
  output job_t                        job,
  output logic [OFFSET_BITS-1:0]      job_ofs
);

  typedef enum logic [5:0] {
    PH_CMD  = 6'b000001,
    PH_OFF  = 6'b000010,
    PH_PAD  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_REP  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             cmd, cmd_next;
  logic [4:0]             units, units_next;
  logic [1:0]             ubi, ubi_next;
  logic [1:0]             obs, obs_next;
  logic                   odd, odd_next;
  logic [OFFSET_BITS-1:0] dest, dest_next;
  logic [3:0][7:0]        rbuf, rbuf_next;
  logic [7:0]             b;
  logic                   acc;

  function automatic phase_t enter_phase(input logic [7:0] c, input logic odd_pos);
    phase_t p;
    if (c[5:4] == SIZE_NONE) begin
      p = PH_CMD;
    end else if (c[5:4] != SIZE_BYTE && odd_pos) begin
      p = PH_PAD;
    end else if (c[7:6] == TYPE_REPEAT) begin
      p = PH_REP;
    end else begin
      p = PH_DATA;
    end
    return p;
  endfunction

  assign tbl.ready = !q_stat.full;
  assign b         = tbl.table_byte;
  assign acc       = tbl.valid && tbl.ready;
  assign job_ofs   = dest;

  always_comb begin
    phase_next = phase;
    cmd_next   = cmd;
    units_next = units;
    ubi_next   = ubi;
    obs_next   = obs;
    odd_next   = odd;
    dest_next  = dest;
    rbuf_next  = rbuf;
    push       = 1'b0;
    job        = '0;
    if (acc && phase != PH_DONE) begin
      odd_next = ~odd;
      case (phase)
        PH_CMD: begin
          if (b == 8'd0) begin
            push       = 1'b1;
            job.kind   = JOB_END;
            phase_next = PH_DONE;
          end else begin
            cmd_next   = b;
            units_next = {1'b0, b[3:0]} + 5'd1;
            ubi_next   = 2'd0;
            obs_next   = 2'd0;
            if (b[7:6] == TYPE_OFF8 || b[7:6] == TYPE_OFF24) begin
              if (b[7:6] == TYPE_OFF24) begin
                dest_next = '0;
              end
              phase_next = PH_OFF;
            end else begin
              phase_next = enter_phase(b, ~odd);
            end
          end
        end
        PH_OFF: begin
          if (cmd[7:6] == TYPE_OFF8) begin
            dest_next  = OFFSET_BITS'(b);
            phase_next = enter_phase(cmd, ~odd);
          end else begin
            dest_next = OFFSET_BITS'({dest, b});
            obs_next  = obs + 2'd1;
            if (obs == 2'd2) begin
              phase_next = enter_phase(cmd, ~odd);
            end
          end
        end
        PH_PAD: begin
          phase_next = (cmd[7:6] == TYPE_REPEAT) ? PH_REP : PH_DATA;
        end
        PH_DATA: begin
          push         = 1'b1;
          job.kind     = JOB_RUN;
          job.size     = SIZE_BYTE;
          job.count    = 5'd1;
          job.data[0]  = b;
          dest_next    = dest + OFFSET_BITS'(1);
          if (ubi == last_idx(cmd[5:4])) begin
            ubi_next   = 2'd0;
            units_next = units - 5'd1;
            if (units == 5'd1) begin
              phase_next = PH_CMD;
            end
          end else begin
            ubi_next = ubi + 2'd1;
          end
        end
        PH_REP: begin
          rbuf_next[ubi] = b;
          if (ubi == last_idx(cmd[5:4])) begin
            push      = 1'b1;
            job.kind  = JOB_RUN;
            job.size  = cmd[5:4];
            job.count = units;
            for (int i = 0; i < 4; i++) begin
              job.data[i] = (ubi == 2'(i)) ? b : rbuf[i];
            end
            dest_next  = dest + OFFSET_BITS'(run_len(units, cmd[5:4]));
            units_next = 5'd0;
            ubi_next   = 2'd0;
            phase_next = PH_CMD;
          end else begin
            ubi_next = ubi + 2'd1;
          end
        end
        default: begin
          phase_next = PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CMD;
      cmd   <= '0;
      units <= '0;
      ubi   <= '0;
      obs   <= '0;
      odd   <= 1'b0;
      dest  <= '0;
    end else begin
      phase <= phase_next;
      cmd   <= cmd_next;
      units <= units_next;
      ubi   <= ubi_next;
      obs   <= obs_next;
      odd   <= odd_next;
      dest  <= dest_next;
    end
  end

  always_ff @(posedge clk) begin
    rbuf <= rbuf_next;
  end

endmodule

`default_nettype wire

@@ sv/sitiu_queue.sv @@
// Small job queue between front and back end.
// Depends on sitiu_pkg.
`default_nettype none

module sitiu_queue
  import sitiu_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      head,
  output q_stat_t           q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;

  assign head         = mem[rp];
  assign q_stat.full  = (cnt == CW'(DEPTH));
  assign q_stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/sitiu_back.sv @@
// Back end: expands queued jobs into one byte write per cycle while the receiver is ready, output register.
// Depends on sitiu_pkg, sitiu_out_if and the assertion macro header.
`default_nettype none
`include "struct_init_table_interpreter_unit_assert.svh"

module sitiu_back
  import sitiu_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire job_t                   q_head,
  input  wire logic [OFFSET_BITS-1:0] q_head_ofs,
  input  wire q_stat_t                q_stat,
  output logic                        pop,
  sitiu_out_if.source                 wr
);

  logic                   active;
  job_t                   e_job, e_job_next;
  logic [1:0]             e_bi;
  logic [OFFSET_BITS-1:0] e_ofs;

  logic                   ov;
  logic [WR_OFS_W-1:0]    o_ofs;
  logic [7:0]             o_data;
  logic                   o_we, o_last, o_end;

  logic                   advance, have, step, fin, is_end, at_unit_end;
  job_t                   src_job;
  logic [1:0]             src_bi;
  logic [OFFSET_BITS-1:0] src_ofs;
  logic [OFFSET_BITS+WR_OFS_W-1:0] ofs_wide;

  assign advance     = !ov || wr.ready;
  assign have        = active || !q_stat.empty;
  assign step        = advance && have;
  assign pop         = step && !active;
  assign src_job     = active ? e_job : q_head;
  assign src_bi      = active ? e_bi : 2'd0;
  assign src_ofs     = active ? e_ofs : q_head_ofs;
  assign is_end      = (src_job.kind == JOB_END);
  assign at_unit_end = (src_bi == last_idx(src_job.size));
  assign fin         = is_end || (at_unit_end && src_job.count == 5'd1);
  assign ofs_wide    = {{WR_OFS_W{1'b0}}, src_ofs};

  always_comb begin
    e_job_next = src_job;
    if (at_unit_end) begin
      e_job_next.count = src_job.count - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (advance) begin
        ov <= have;
      end
      if (step) begin
        active <= !fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_ofs  <= ofs_wide[WR_OFS_W-1:0];
      o_data <= is_end ? 8'd0 : src_job.data[src_bi];
      o_we   <= !is_end;
      o_last <= fin;
      o_end  <= is_end;
      e_job  <= e_job_next;
      e_bi   <= at_unit_end ? 2'd0 : src_bi + 2'd1;
      e_ofs  <= src_ofs + OFFSET_BITS'(1);
    end
  end

  assign wr.valid        = ov;
  assign wr.write_offset = o_ofs;
  assign wr.write_data   = o_data;
  assign wr.write_enable = o_we;
  assign wr.last_of_run  = o_last;
  assign wr.table_end    = o_end;

  `SITIU_ASSERT_IMP(a_active_shown, active, ov)
  `SITIU_ASSERT_IMP(a_pop_idle, pop, !active && !q_stat.empty)
  `SITIU_ASSERT_IMP(a_end_marker, ov && o_end, o_last && !o_we)
  `SITIU_ASSERT_NEXT(a_run_cont, step && !fin, active)

endmodule

`default_nettype wire

@@ sv/struct_init_table_interpreter_unit.sv @@
// Init-table interpreter, top level: front end, job queue, back end.
// Depends on sitiu_pkg, sitiu_in_if, sitiu_out_if, sitiu_front, sitiu_queue, sitiu_back.
//
// Takes a structure initialization table one byte per transaction and gives
// byte writes (offset from the structure base, data) plus a final end marker.
// The front end accepts one table byte per cycle while the job queue
// (QUEUE_DEPTH entries) has room; nonzero command, offset and pad bytes make no job.
// The back end sends one write per cycle from its output register while the
// receiver is ready; a copy byte gives one write and a repeat run gives count *
// unit writes (up to 64), while the front keeps parsing until the queue fills.
// A data byte passes the job queue and the output register before its write.
// After the zero command every further byte is taken and dropped until reset.
`default_nettype none

module struct_init_table_interpreter_unit
  import sitiu_pkg::*;
#(
  parameter int OFFSET_BITS = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sitiu_in_if.sink    tbl,
  sitiu_out_if.source wr
);

  localparam int QW = JOB_W + OFFSET_BITS;

  logic                   push, pop;
  job_t                   f_job, h_job;
  logic [OFFSET_BITS-1:0] f_ofs, h_ofs;
  logic [QW-1:0]          q_in, q_head;
  q_stat_t                q_stat;

  assign q_in  = {f_ofs, f_job};
  assign h_job = q_head[JOB_W-1:0];
  assign h_ofs = q_head[QW-1:JOB_W];

  sitiu_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .tbl     (tbl),
    .q_stat  (q_stat),
    .push    (push),
    .job     (f_job),
    .job_ofs (f_ofs)
  );

  sitiu_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  sitiu_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_head     (h_job),
    .q_head_ofs (h_ofs),
    .q_stat     (q_stat),
    .pop        (pop),
    .wr         (wr)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for struct_init_table_interpreter_unit: streams a directed table, random commands
// and the terminator, and checks each write against a predictor of the table parser.
// Depends on sitiu_pkg, sitiu_in_if, sitiu_out_if and the RTL top level.

module tb_top;
  import sitiu_pkg::*;

  localparam logic [7:0] END_OF_TABLE = 8'h00;
  localparam int RANDOM_BYTES = 375;
  localparam int MAX_WRITES = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned LIMIT_NS = 2_400_000;

  typedef enum logic [2:0] {
    AT_CMD, AT_OFFSET, AT_PAD, AT_DATA, AT_REPEAT, AT_DONE
  } parse_phase_t;

  typedef struct packed {
    parse_phase_t    phase;
    logic [7:0]      cmd;
    logic [4:0]      units_left;
    logic [2:0]      byte_idx;
    logic [3:0][7:0] unit_buf;
    logic [23:0]     dest;
    logic [1:0]      ofs_seen;
    logic            odd;
  } parse_ctx_t;

  typedef struct packed {
    logic [23:0] ofs;
    logic [7:0]  data;
    logic        we;
    logic        last;
    logic        tend;
  } write_rec_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    write_rec_t exp;
  } stim_row_t;

  localparam stim_row_t HEAD_ROWS [26] = '{
    '{8'h20, 1'b0, '0},
    '{8'hA5, 1'b1, '{24'h000000, 8'hA5, 1'b1, 1'b1, 1'b0}},
    '{8'hE0, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{24'hFFFFFF, 8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'h21, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h81, 1'b0, '0},
    '{8'h4F, 1'b0, '0},  // repeat 16 longs, pad first
    '{8'h5A, 1'b0, '0},
    '{8'hDE, 1'b0, '0},
    '{8'hAD, 1'b0, '0},
    '{8'hBE, 1'b0, '0},
    '{8'hEF, 1'b0, '0},
    '{8'h90, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h12, 1'b0, '0},
    '{8'h34, 1'b0, '0},
    '{8'hB5, 1'b0, '0},  // 8-bit offset, no data
    '{8'h10, 1'b0, '0},
    '{8'h53, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}
  };

  localparam logic [7:0] AFTER_END [4] = '{END_OF_TABLE, 8'hFF, 8'h4F, 8'h01};

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sitiu_in_if  tbl_if ();
  sitiu_out_if wr_if ();

  struct_init_table_interpreter_unit dut (
    .clk (clk),
    .rst (rst),
    .tbl (tbl_if),
    .wr  (wr_if)
  );

  parse_ctx_t table_state = '0;
  parse_ctx_t stream_state = '0;
  write_rec_t expected_writes [$];
  stim_row_t  row_notes [$];
  int         mismatches = 0;
  int         burst_left = 0;

  function automatic int unsigned unit_bytes(input logic [1:0] size);
    case (size)
      SIZE_LONG: return 4;
      SIZE_WORD: return 2;
      SIZE_BYTE: return 1;
      default:   return 0;
    endcase
  endfunction

  function automatic parse_phase_t phase_after_header(input parse_ctx_t c);
    int unsigned unit;
    unit = unit_bytes(c.cmd[5:4]);
    if (unit == 0) return AT_CMD;
    if (unit >= 2 && c.odd) return AT_PAD;
    return (c.cmd[7:6] == TYPE_REPEAT) ? AT_REPEAT : AT_DATA;
  endfunction

  function automatic parse_ctx_t interpret_byte(input parse_ctx_t cur, input logic [7:0] b,
                                                output int n, output write_rec_t w [MAX_WRITES]);
    parse_ctx_t  c;
    int unsigned unit;
    c = cur;
    n = 0;
    unit = unit_bytes(c.cmd[5:4]);
    if (c.phase == AT_DONE) return c;
    c.odd = ~c.odd;  // parity of the next byte
    case (c.phase)
      AT_CMD: begin
        if (b == END_OF_TABLE) begin
          c.phase = AT_DONE;
          w[0] = '{ofs: c.dest, data: 8'h00, we: 1'b0, last: 1'b1, tend: 1'b1};
          n = 1;
          return c;
        end
        c.cmd = b;
        c.units_left = {1'b0, b[3:0]} + 5'd1;
        c.byte_idx = '0;
        c.ofs_seen = '0;
        if (b[7:6] == TYPE_OFF8 || b[7:6] == TYPE_OFF24) begin
          if (b[7:6] == TYPE_OFF24) c.dest = '0;
          c.phase = AT_OFFSET;
        end else begin
          c.phase = phase_after_header(c);
        end
      end
      AT_OFFSET: begin
        if (c.cmd[7:6] == TYPE_OFF8) begin
          c.dest = {16'h0000, b};
          c.phase = phase_after_header(c);
        end else begin
          c.dest = {c.dest[15:0], b};
          c.ofs_seen = c.ofs_seen + 2'd1;
          if (c.ofs_seen == 2'd3) c.phase = phase_after_header(c);
        end
      end
      AT_PAD: c.phase = (c.cmd[7:6] == TYPE_REPEAT) ? AT_REPEAT : AT_DATA;
      AT_DATA: begin
        w[0] = '{ofs: c.dest, data: b, we: 1'b1, last: 1'b0, tend: 1'b0};
        n = 1;
        c.dest = c.dest + 24'd1;
        c.byte_idx = c.byte_idx + 3'd1;
        if (c.byte_idx >= unit) begin
          c.byte_idx = '0;
          c.units_left = c.units_left - 5'd1;
          if (c.units_left == 0) c.phase = AT_CMD;
        end
      end
      AT_REPEAT: begin
        c.unit_buf[c.byte_idx[1:0]] = b;
        c.byte_idx = c.byte_idx + 3'd1;
        if (c.byte_idx >= unit) begin
          for (int u = 0; u < c.units_left; u++) begin
            for (int i = 0; i < unit; i++) begin
              w[n] = '{ofs: c.dest, data: c.unit_buf[i], we: 1'b1, last: 1'b0, tend: 1'b0};
              n++;
              c.dest = c.dest + 24'd1;
            end
          end
          c.byte_idx = '0;
          c.units_left = '0;
          c.phase = AT_CMD;
        end
      end
      default: c.phase = AT_CMD;
    endcase
    if (n > 0) w[n-1].last = 1'b1;
    return c;
  endfunction

  function automatic logic [7:0] pick_command();
    logic [1:0] kind;
    logic [1:0] size;
    logic [3:0] cnt;
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    kind = 2'($urandom_range(0, 3));
    size = ($urandom_range(0, 7) == 0) ? SIZE_NONE : 2'($urandom_range(0, 2));
    cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    c = {kind, size, cnt};
    if (c == END_OF_TABLE) c = 8'h01;
    return c;
  endfunction

  function automatic logic [7:0] pick_table_byte(input parse_ctx_t c);
    if (c.phase == AT_CMD) return pick_command();
    if (c.phase == AT_OFFSET && $urandom_range(0, 3) == 0) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string what, input write_rec_t exp, input write_rec_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch, %s: exp ofs=%06h data=%02h we=%b last=%b end=%b,",
                " got ofs=%06h data=%02h we=%b last=%b end=%b"},
               $realtime, what, exp.ofs, exp.data, exp.we, exp.last, exp.tend,
               got.ofs, got.data, got.we, got.last, got.tend);
  endtask

  task automatic send_row(input stim_row_t row);
    int         gap;
    int         n;
    write_rec_t scratch [MAX_WRITES];
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        tbl_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    stream_state = interpret_byte(stream_state, row.b, n, scratch);
    row_notes.push_back(row);
    tbl_if.valid = 1'b1;
    tbl_if.table_byte = row.b;
    do @(posedge clk); while (!tbl_if.ready);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_row('{b: b, typed: 1'b0, exp: '0});
  endtask

  always @(posedge clk) begin
    stim_row_t  note;
    write_rec_t fresh [MAX_WRITES];
    write_rec_t got;
    write_rec_t exp;
    int         n;
    if (!rst) begin
      if (tbl_if.valid && tbl_if.ready) begin
        note = row_notes.pop_front();
        table_state = interpret_byte(table_state, tbl_if.table_byte, n, fresh);
        if (note.typed) expected_writes.push_back(note.exp);
        else for (int i = 0; i < n; i++) expected_writes.push_back(fresh[i]);
      end
      if (wr_if.valid && wr_if.ready) begin
        got = '{ofs: wr_if.write_offset, data: wr_if.write_data, we: wr_if.write_enable,
                last: wr_if.last_of_run, tend: wr_if.table_end};
        if (expected_writes.size() == 0) begin
          note_mismatch("no write pending", '0, got);
        end else begin
          exp = expected_writes.pop_front();
          if (got.ofs !== exp.ofs || got.data !== exp.data || got.we !== exp.we ||
              got.last !== exp.last || got.tend !== exp.tend)
            note_mismatch("field", exp, got);
        end
      end
    end
  end

  // Receiver: alternating ready runs and short stalls.
  initial begin
    bit sink_up;
    int sink_count;
    sink_up = 1'b0;
    sink_count = 0;
    wr_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_count == 0) begin
        sink_up = !sink_up;
        if (sink_up)
          sink_count = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 8);
        else
          sink_count = $urandom_range(1, 4);
      end
      sink_count--;
      wr_if.ready = sink_up;
    end
  end

  initial begin
    tbl_if.valid = 1'b0;
    tbl_if.table_byte = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (HEAD_ROWS[i]) send_row(HEAD_ROWS[i]);
    for (int i = 0; i < RANDOM_BYTES; i++) send_plain(pick_table_byte(stream_state));
    while (stream_state.phase != AT_CMD) send_plain(pick_table_byte(stream_state));
    foreach (AFTER_END[i]) send_plain(AFTER_END[i]);
    @(negedge clk);
    tbl_if.valid = 1'b0;

    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout, %0d writes still pending", expected_writes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
